@@ rtl/dma4_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dma4_pkg;

    localparam int NUM_CH   = 4;
    localparam int CH_W     = 2;
    localparam int ADDR_W   = 32;
    localparam int COUNT_W  = 28;
    localparam int CTRL_W   = 16;

    // count masks, the last channel keeps one bit less
    localparam logic [COUNT_W-1:0] COUNT_MASK      = 28'h0FFFFFFF;
    localparam logic [COUNT_W-1:0] COUNT_MASK_LAST = 28'h07FFFFFF;

    // control register bits
    localparam int BIT_ENABLE = 15;
    localparam int BIT_WORD   = 10;
    localparam int BIT_REPEAT = 9;
    localparam int DCTL_LO    = 5;
    localparam int SCTL_LO    = 7;

    // operation codes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // register selects
    localparam logic [1:0] REG_DEST    = 2'd0;
    localparam logic [1:0] REG_SOURCE  = 2'd1;
    localparam logic [1:0] REG_COUNT   = 2'd2;
    localparam logic [1:0] REG_CONTROL = 2'd3;

    // address step modes
    localparam logic [1:0] STEP_INC        = 2'b00;
    localparam logic [1:0] STEP_DEC        = 2'b01;
    localparam logic [1:0] STEP_INC_RELOAD = 2'b11;

    typedef struct packed {
        logic              operation;
        logic [CH_W-1:0]   channel;
        logic [1:0]        register_select;
        logic [ADDR_W-1:0] write_data;
    } dma4_req_t;

    typedef struct packed {
        logic              cpu_stall;
        logic              transfer_valid;
        logic              transfer_word;
        logic [ADDR_W-1:0] read_address;
        logic [ADDR_W-1:0] write_address;
        logic [CH_W-1:0]   transfer_channel;
        logic [NUM_CH-1:0] enable_bits;
    } dma4_rsp_t;

endpackage

`default_nettype wire

@@ rtl/four_channel_dma_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Four-channel DMA controller driven one bus tick at a time. Each request word is
// either a channel register write or one tick; every request gives exactly one
// response word. Requests are taken one per clock: the whole update of the channel
// state is done in the accepting cycle and the response sits in a single output
// register, so a new request is accepted every cycle as long as that register is
// empty or being drained in the same cycle. The response is valid in the cycle after
// the accept.
module four_channel_dma_controller (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  req_valid,
    output logic                 req_ready,
    input  dma4_pkg::dma4_req_t  req,
    output logic                 rsp_valid,
    input  wire                  rsp_ready,
    output dma4_pkg::dma4_rsp_t  rsp
);

    import dma4_pkg::*;

    logic [ADDR_W-1:0]  dest_addr_reg  [NUM_CH];
    logic [ADDR_W-1:0]  dest_addr_next [NUM_CH];
    logic [ADDR_W-1:0]  src_addr_reg   [NUM_CH];
    logic [ADDR_W-1:0]  src_addr_next  [NUM_CH];
    logic [COUNT_W-1:0] count_reg      [NUM_CH];
    logic [COUNT_W-1:0] count_next     [NUM_CH];
    logic [CTRL_W-1:0]  control_reg    [NUM_CH];
    logic [CTRL_W-1:0]  control_next   [NUM_CH];
    logic [ADDR_W-1:0]  cur_dest_reg   [NUM_CH];
    logic [ADDR_W-1:0]  cur_dest_next  [NUM_CH];
    logic [ADDR_W-1:0]  cur_src_reg    [NUM_CH];
    logic [ADDR_W-1:0]  cur_src_next   [NUM_CH];
    logic [COUNT_W-1:0] bytes_left_reg [NUM_CH];
    logic [COUNT_W-1:0] bytes_left_next[NUM_CH];
    logic [NUM_CH-1:0]  active_reg;
    logic [NUM_CH-1:0]  active_next;
    logic               phase_reg;
    logic               phase_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    dma4_rsp_t          rsp_reg;
    dma4_rsp_t          rsp_next;

    logic               req_fire;
    logic [NUM_CH-1:0]  start_vec;
    logic [NUM_CH-1:0]  start_one;
    logic [NUM_CH-1:0]  act_one;

    // per-channel stepped values for a copy
    logic [ADDR_W-1:0]  dest_step   [NUM_CH];
    logic [ADDR_W-1:0]  src_step    [NUM_CH];
    logic [COUNT_W-1:0] left_after  [NUM_CH];
    logic [COUNT_W-1:0] load_count  [NUM_CH];

    assign req_fire  = req_valid && req_ready;
    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_CH; i++)
        begin
            start_vec[i] = !active_reg[i] && control_reg[i][BIT_ENABLE];
        end
        // lowest set bit
        start_one = start_vec & (~start_vec + NUM_CH'(1));
        act_one   = active_reg & (~active_reg + NUM_CH'(1));
    end

    always_comb
    begin
        logic [ADDR_W-1:0] inc;
        logic [1:0]        dctl;
        logic [1:0]        sctl;
        for (int i = 0; i < NUM_CH; i++)
        begin
            inc  = control_reg[i][BIT_WORD] ? ADDR_W'(4) : ADDR_W'(2);
            dctl = control_reg[i][DCTL_LO +: 2];
            sctl = control_reg[i][SCTL_LO +: 2];
            if (dctl == STEP_INC || dctl == STEP_INC_RELOAD)
                dest_step[i] = cur_dest_reg[i] + inc;
            else if (dctl == STEP_DEC)
                dest_step[i] = cur_dest_reg[i] - inc;
            else
                dest_step[i] = cur_dest_reg[i];
            if (sctl == STEP_INC)
                src_step[i] = cur_src_reg[i] + inc;
            else if (sctl == STEP_DEC)
                src_step[i] = cur_src_reg[i] - inc;
            else
                src_step[i] = cur_src_reg[i];
            // count saturates at zero
            if (bytes_left_reg[i] < COUNT_W'(inc))
                left_after[i] = '0;
            else
                left_after[i] = bytes_left_reg[i] - COUNT_W'(inc);
            load_count[i] = count_reg[i]
                & ((i == NUM_CH - 1) ? COUNT_MASK_LAST : COUNT_MASK);
        end
    end

    always_comb
    begin
        dest_addr_next  = dest_addr_reg;
        src_addr_next   = src_addr_reg;
        count_next      = count_reg;
        control_next    = control_reg;
        cur_dest_next   = cur_dest_reg;
        cur_src_next    = cur_src_reg;
        bytes_left_next = bytes_left_reg;
        active_next     = active_reg;
        phase_next      = phase_reg;
        rsp_next        = '0;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;

        if (req_fire)
        begin
            rsp_valid_next = 1'b1;
            if (req.operation == OP_WRITE)
            begin
                for (int i = 0; i < NUM_CH; i++)
                begin
                    if (req.channel == CH_W'(i))
                    begin
                        case (req.register_select)
                            REG_DEST:    dest_addr_next[i] = req.write_data;
                            REG_SOURCE:  src_addr_next[i]  = req.write_data;
                            REG_COUNT:   count_next[i]     = req.write_data[COUNT_W-1:0];
                            REG_CONTROL: control_next[i]   = req.write_data[CTRL_W-1:0];
                            default:     control_next[i]   = control_reg[i];
                        endcase
                    end
                end
            end
            else if (start_vec != '0)
            begin
                rsp_next.cpu_stall = 1'b1;
                for (int i = 0; i < NUM_CH; i++)
                begin
                    if (start_one[i])
                    begin
                        cur_dest_next[i]   = dest_addr_reg[i];
                        cur_src_next[i]    = src_addr_reg[i];
                        bytes_left_next[i] = load_count[i];
                        active_next[i]     = 1'b1;
                    end
                end
            end
            else if (active_reg != '0)
            begin
                phase_next = !phase_reg;
                // copy on the tick where the phase turns to one
                if (!phase_reg)
                begin
                    rsp_next.cpu_stall      = 1'b1;
                    rsp_next.transfer_valid = 1'b1;
                    for (int i = 0; i < NUM_CH; i++)
                    begin
                        if (act_one[i])
                        begin
                            rsp_next.transfer_word    = control_reg[i][BIT_WORD];
                            rsp_next.read_address     = cur_src_reg[i];
                            rsp_next.write_address    = cur_dest_reg[i];
                            rsp_next.transfer_channel = CH_W'(i);
                            cur_dest_next[i]          = dest_step[i];
                            cur_src_next[i]           = src_step[i];
                            bytes_left_next[i]        = left_after[i];
                            if (left_after[i] == '0)
                            begin
                                if (control_reg[i][BIT_REPEAT])
                                begin
                                    if (control_reg[i][DCTL_LO +: 2] == STEP_INC_RELOAD)
                                        cur_dest_next[i] = dest_addr_reg[i];
                                    bytes_left_next[i] = load_count[i];
                                end
                                else
                                begin
                                    active_next[i]              = 1'b0;
                                    control_next[i][BIT_ENABLE] = 1'b0;
                                end
                            end
                        end
                    end
                end
            end
            for (int i = 0; i < NUM_CH; i++)
            begin
                rsp_next.enable_bits[i] = control_next[i][BIT_ENABLE];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                dest_addr_reg[i]  <= '0;
                src_addr_reg[i]   <= '0;
                count_reg[i]      <= '0;
                control_reg[i]    <= '0;
                cur_dest_reg[i]   <= '0;
                cur_src_reg[i]    <= '0;
                bytes_left_reg[i] <= '0;
            end
            active_reg    <= '0;
            phase_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            dest_addr_reg  <= dest_addr_next;
            src_addr_reg   <= src_addr_next;
            count_reg      <= count_next;
            control_reg    <= control_next;
            cur_dest_reg   <= cur_dest_next;
            cur_src_reg    <= cur_src_next;
            bytes_left_reg <= bytes_left_next;
            active_reg     <= active_next;
            phase_reg      <= phase_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // response payload holds while stalled
    always_ff @(posedge clk)
    begin
        if (req_fire)
            rsp_reg <= rsp_next;
    end

    a_copy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.transfer_valid |-> rsp.cpu_stall)
        else $error("copy issued without cpu stall");

    a_no_copy_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.transfer_valid |->
            rsp.read_address == '0 && rsp.write_address == '0
            && rsp.transfer_channel == '0 && !rsp.transfer_word)
        else $error("copy fields nonzero without a copy");

    a_write_keeps_run: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && req.operation == OP_WRITE |=>
            $stable(active_reg) && $stable(phase_reg))
        else $error("register write changed channel run state");

    a_idle_phase: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && req.operation == OP_TICK && active_reg == '0 && start_vec == '0
            |=> $stable(phase_reg) && !rsp.cpu_stall)
        else $error("idle tick moved phase or stalled");

endmodule

`default_nettype wire
